FILE: design/one_bit_run_length_frame_decoder_unit_assert.svh
// Assertion macros for the run-length frame decoder.
// Included by modules that check their own logic; expects clk_i and rst_ni in scope.
`ifndef ONE_BIT_RUN_LENGTH_FRAME_DECODER_UNIT_ASSERT_SVH
`define ONE_BIT_RUN_LENGTH_FRAME_DECODER_UNIT_ASSERT_SVH

// same-cycle implication
`define RLFD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rlfd assertion failed");

// next-cycle implication
`define RLFD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rlfd assertion failed");

`endif

FILE: design/rlfd_pkg.sv
// Shared types and constants of the run-length frame decoder.
// No dependencies; used by the top level, rlfd_out_if, rlfd_cfg, rlfd_ctrl and rlfd_dp.
package rlfd_pkg;

  localparam int ColorBitsDef = 16;
  localparam int PixOutW      = 16;
  localparam int AddrW        = 5;
  localparam logic [7:0] MinWidth = 8'd4;

  localparam logic ActStart = 1'b0;
  localparam logic ActData  = 1'b1;

  typedef enum logic [2:0] {
    RegWidth  = 3'd0,
    RegHeight = 3'd1,
    RegLenBits = 3'd2,
    RegSkip   = 3'd3,
    RegFore   = 3'd4,
    RegBack   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [7:0]  frame_width;
    logic [7:0]  frame_height;
    logic [2:0]  length_bits;
    logic [2:0]  skip_bits;
    logic [15:0] fore_color;
    logic [15:0] back_color;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic unit_take;
    logic seg_step;
  } cmd_t;

  typedef struct packed {
    logic frame_done;
    logic unit_avail;
    logic seg_pending;
    logic out_free;
  } status_t;

endpackage

FILE: design/rlfd_in_if.sv
// Input word channel of the run-length frame decoder.
// Depends on nothing; carries action and data_byte.
interface rlfd_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink (input valid, input action, input data_byte, output ready);
endinterface

FILE: design/rlfd_out_if.sv
// Output segment channel of the run-length frame decoder.
// Depends on rlfd_pkg for the pixel width.
interface rlfd_out_if;
  logic                             valid;
  logic                             ready;
  logic [rlfd_pkg::PixOutW-1:0]     pixel_value;
  logic [7:0]                       row;
  logic [7:0]                       col_start;
  logic [7:0]                       seg_length;
  logic                             line_end;
  logic                             frame_end;
  logic                             last_of_item;

  modport source (output valid, output pixel_value, output row, output col_start,
                  output seg_length, output line_end, output frame_end,
                  output last_of_item, input ready);
  modport sink (input valid, input pixel_value, input row, input col_start,
                input seg_length, input line_end, input frame_end,
                input last_of_item, output ready);
endinterface

FILE: design/one_bit_run_length_frame_decoder_unit.sv
// One-bit run-length frame decoder, top level.
// Depends on rlfd_pkg, rlfd_in_if, rlfd_out_if, rlfd_cfg, rlfd_ctrl and rlfd_dp.
//
// Usage: the input channel takes one word per coded byte or start command;
// action 0 starts a frame, action 1 carries data_byte, read MSB first.
// The output channel gives one word per line-clipped segment, with row,
// first column, length, line and frame end flags, and last_of_item on the
// final segment a byte causes. Registers are written over the APB port;
// the user must do so only while the block is idle; it is not enforced.
// Sequence: a start word or an ignored byte is handled in the idle state alone.
// A data byte is loaded, then each unit in turn is split, its segments are
// stepped one at a time and the unit is closed; the byte ends when no whole
// unit is left. The shared unit splitter and the single segment stepper
// bound how fast a byte is decoded.
// Reset: no frame is active; data words are dropped until a start word.
// When the receiver stalls, the output register holds its segment and the
// segment stepper waits; input is not taken until the byte is done.
module one_bit_run_length_frame_decoder_unit #(
  parameter int COLOR_BITS = rlfd_pkg::ColorBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rlfd_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  rlfd_in_if.sink                     in_i,
  rlfd_out_if.source                  out_o
);

  rlfd_pkg::cfg_t    cfg;
  rlfd_pkg::cmd_t    cmd;
  rlfd_pkg::status_t status;

  rlfd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rlfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rlfd_dp #(
    .COLOR_BITS (COLOR_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_action_i (in_i.action),
    .in_data_i   (in_i.data_byte),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_pixel_o (out_o.pixel_value),
    .out_row_o   (out_o.row),
    .out_col_o   (out_o.col_start),
    .out_len_o   (out_o.seg_length),
    .out_le_o    (out_o.line_end),
    .out_fe_o    (out_o.frame_end),
    .out_last_o  (out_o.last_of_item)
  );

endmodule

FILE: design/rlfd_cfg.sv
// Configuration register file with APB-style access.
// Depends on rlfd_pkg for the register indexes and the cfg_t bundle.
module rlfd_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rlfd_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output rlfd_pkg::cfg_t              cfg_o
);

  rlfd_pkg::cfg_t   cfg_q;
  rlfd_pkg::reg_idx_e idx;
  logic             wr_en;

  assign idx    = rlfd_pkg::reg_idx_e'(paddr[rlfd_pkg::AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= 8'd8;
      cfg_q.frame_height <= 8'd8;
      cfg_q.length_bits  <= 3'd7;
      cfg_q.skip_bits    <= 3'd0;
      cfg_q.fore_color   <= 16'hFFFF;
      cfg_q.back_color   <= 16'h0000;
    end else if (wr_en) begin
      unique case (idx)
        rlfd_pkg::RegWidth:   cfg_q.frame_width  <= pwdata[7:0];
        rlfd_pkg::RegHeight:  cfg_q.frame_height <= pwdata[7:0];
        rlfd_pkg::RegLenBits: cfg_q.length_bits  <= pwdata[2:0];
        rlfd_pkg::RegSkip:    cfg_q.skip_bits    <= pwdata[2:0];
        rlfd_pkg::RegFore:    cfg_q.fore_color   <= pwdata[15:0];
        rlfd_pkg::RegBack:    cfg_q.back_color   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      rlfd_pkg::RegWidth:   prdata = {24'd0, cfg_q.frame_width};
      rlfd_pkg::RegHeight:  prdata = {24'd0, cfg_q.frame_height};
      rlfd_pkg::RegLenBits: prdata = {29'd0, cfg_q.length_bits};
      rlfd_pkg::RegSkip:    prdata = {29'd0, cfg_q.skip_bits};
      rlfd_pkg::RegFore:    prdata = {16'd0, cfg_q.fore_color};
      rlfd_pkg::RegBack:    prdata = {16'd0, cfg_q.back_color};
      default:              prdata = 32'd0;
    endcase
  end

endmodule

FILE: design/rlfd_ctrl.sv
// Sequencing controller: accept a word, take units, step segments.
// Depends on rlfd_pkg for the command and status bundles.
module rlfd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_action_i,
  output logic                in_ready_o,
  input  rlfd_pkg::status_t   status_i,
  output rlfd_pkg::cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StUnit,
    StSeg
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        cmd_o.load = accept;
        if (accept && in_action_i == rlfd_pkg::ActData && !status_i.frame_done) begin
          state_d = StUnit;
        end
      end
      StUnit: begin
        if (status_i.unit_avail) begin
          cmd_o.unit_take = 1'b1;
          state_d = StSeg;
        end else begin
          state_d = StIdle;
        end
      end
      StSeg: begin
        if (!status_i.seg_pending) begin
          state_d = StUnit;
        end else begin
          cmd_o.seg_step = status_i.out_free;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: design/rlfd_dp.sv
// Decode datapath: bit accumulator, unit split, line clipping, output register.
// Depends on rlfd_pkg and the assertion macro header.
`include "one_bit_run_length_frame_decoder_unit_assert.svh"

module rlfd_dp #(
  parameter int COLOR_BITS = rlfd_pkg::ColorBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rlfd_pkg::cfg_t                  cfg_i,
  input  rlfd_pkg::cmd_t                  cmd_i,
  output rlfd_pkg::status_t               status_o,
  input  logic                            in_action_i,
  input  logic [7:0]                      in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [rlfd_pkg::PixOutW-1:0]    out_pixel_o,
  output logic [7:0]                      out_row_o,
  output logic [7:0]                      out_col_o,
  output logic [7:0]                      out_len_o,
  output logic                            out_le_o,
  output logic                            out_fe_o,
  output logic                            out_last_o
);

  localparam int PixW = (COLOR_BITS < rlfd_pkg::PixOutW) ? COLOR_BITS : rlfd_pkg::PixOutW;

  logic [14:0]     acc_q;
  logic [3:0]      cnt_q;
  logic [2:0]      skip_q;
  logic [7:0]      row_q, col_q, len_q;
  logic            done_q;
  logic [PixW-1:0] pix_q;

  logic            ov_q;
  logic [PixW-1:0] opix_q;
  logic [7:0]      orow_q, ocol_q, olen_q;
  logic            ole_q, ofe_q, olast_q;

  logic [3:0]  usize, nbits, shift;
  logic [7:0]  byte_m;
  logic [14:0] acc_ld, acc_sh, acc_rem;
  logic [3:0]  cnt_ld;
  logic [6:0]  lmask;
  logic        color;
  logic [7:0]  len_new;
  logic [7:0]  w, h, room, seg, col_sum;
  logic        row_over, col_over, le, fe, last, out_free;

  assign usize   = {1'b0, cfg_i.length_bits} + 4'd1;
  assign nbits   = 4'd8 - {1'b0, skip_q};
  assign byte_m  = in_data_i & 8'((9'd1 << nbits) - 9'd1);
  assign acc_ld  = (acc_q << nbits) | {7'd0, byte_m};
  assign cnt_ld  = cnt_q + nbits;

  assign shift   = cnt_q - usize;
  assign acc_sh  = acc_q >> shift;
  assign acc_rem = acc_q & 15'((16'd1 << shift) - 16'd1);
  assign lmask   = 7'((8'd1 << cfg_i.length_bits) - 8'd1);
  assign color   = acc_sh[{1'b0, cfg_i.length_bits}];
  assign len_new = {1'b0, acc_sh[6:0] & lmask} + 8'd1;

  assign w        = (cfg_i.frame_width < rlfd_pkg::MinWidth) ? rlfd_pkg::MinWidth
                                                            : cfg_i.frame_width;
  assign h        = (cfg_i.frame_height == 8'd0) ? 8'd1 : cfg_i.frame_height;
  assign row_over = (row_q >= h);
  assign col_over = (col_q >= w);
  assign room     = w - col_q;
  assign seg      = (len_q < room) ? len_q : room;
  assign col_sum  = col_q + seg;
  assign le       = (col_sum == w);
  assign fe       = le && (({1'b0, row_q} + 9'd1) >= {1'b0, h});
  assign last     = fe || ((len_q == seg) && (cnt_q < usize));
  assign out_free = !ov_q || out_ready_i;

  assign status_o.frame_done  = done_q;
  assign status_o.unit_avail  = !done_q && (cnt_q >= usize);
  assign status_o.seg_pending = !done_q && (len_q != 8'd0);
  assign status_o.out_free    = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      cnt_q  <= '0;
      skip_q <= '0;
      row_q  <= '0;
      col_q  <= '0;
      len_q  <= '0;
      done_q <= 1'b1;
      ov_q   <= 1'b0;
    end else begin
      if (cmd_i.seg_step && !row_over && !col_over) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
      if (cmd_i.load) begin
        if (in_action_i == rlfd_pkg::ActStart) begin
          acc_q  <= '0;
          cnt_q  <= '0;
          row_q  <= '0;
          col_q  <= '0;
          len_q  <= '0;
          skip_q <= cfg_i.skip_bits;
          done_q <= 1'b0;
        end else if (!done_q) begin
          acc_q  <= acc_ld;
          cnt_q  <= cnt_ld;
          skip_q <= '0;
        end
      end
      if (cmd_i.unit_take) begin
        acc_q <= acc_rem;
        cnt_q <= shift;
        len_q <= len_new;
      end
      if (cmd_i.seg_step) begin
        if (row_over) begin
          done_q <= 1'b1;
          acc_q  <= '0;
          cnt_q  <= '0;
          len_q  <= '0;
        end else if (col_over) begin
          col_q <= '0;
          row_q <= row_q + 8'd1;
        end else begin
          len_q <= fe ? 8'd0 : len_q - seg;
          if (le) begin
            col_q <= '0;
            row_q <= row_q + 8'd1;
          end else begin
            col_q <= col_sum;
          end
          if (fe) begin
            done_q <= 1'b1;
            acc_q  <= '0;
            cnt_q  <= '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.unit_take) begin
      pix_q <= color ? cfg_i.fore_color[PixW-1:0] : cfg_i.back_color[PixW-1:0];
    end
    if (cmd_i.seg_step && !row_over && !col_over) begin
      opix_q  <= pix_q;
      orow_q  <= row_q;
      ocol_q  <= col_q;
      olen_q  <= seg;
      ole_q   <= le;
      ofe_q   <= fe;
      olast_q <= last;
    end
  end

  assign out_valid_o = ov_q;
  assign out_pixel_o = rlfd_pkg::PixOutW'(opix_q);
  assign out_row_o   = orow_q;
  assign out_col_o   = ocol_q;
  assign out_len_o   = olen_q;
  assign out_le_o    = ole_q;
  assign out_fe_o    = ofe_q;
  assign out_last_o  = olast_q;

  `RLFD_ASSERT_NOW(a_done_no_bits, done_q, cnt_q == 4'd0 && len_q == 8'd0)
  `RLFD_ASSERT_NOW(a_step_needs_room, cmd_i.seg_step, out_free)
  `RLFD_ASSERT_NOW(a_fe_is_last, ov_q && ofe_q, olast_q && ole_q)
  `RLFD_ASSERT_NXT(a_fe_ends_frame, cmd_i.seg_step && !row_over && !col_over && fe, done_q)

endmodule
